### rtl/core/tpr_pkg.sv
// Package for the tilemap pixel renderer: store sizes, tile map layout, commands and states.
`timescale 1ns / 1ps
package tpr_pkg;

    localparam int TILE_WORDS      = 32768;
    localparam int CHAR_WORDS      = 262144;
    localparam int PALETTE_WORDS   = 8192;
    localparam int TRANSLATE_WORDS = 24576;
    localparam int GAMMA_WORDS     = 256;
    localparam int SCREEN_WIDTH    = 496;
    localparam int SCREEN_HEIGHT   = 384;

    localparam int TILE_AW  = 15;
    localparam int PAL_AW   = 13;
    localparam int XL_AW    = 15;
    localparam int GAMMA_AW = 8;

    localparam logic [TILE_AW-1:0] HSCROLL_BASE = 15'h5000;
    localparam logic [TILE_AW-1:0] VSCROLL_BASE = 15'h5004;
    localparam logic [TILE_AW-1:0] MASK_LO      = 15'h6000;
    localparam logic [TILE_AW-1:0] MASK_HI      = 15'h6800;
    localparam logic [XL_AW-1:0]   XL_R         = 15'h0040;
    localparam logic [XL_AW-1:0]   XL_G         = 15'h2040;
    localparam logic [XL_AW-1:0]   XL_B         = 15'h4040;
    localparam logic [1:0]         MODE_VDIV    = 2'd1;

    typedef enum logic [2:0] {
        CMD_TILE  = 3'd0,
        CMD_CHAR  = 3'd1,
        CMD_PAL   = 3'd2,
        CMD_XL    = 3'd3,
        CMD_GAMMA = 3'd4,
        CMD_QUERY = 3'd5
    } cmd_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HS,
        S_VS,
        S_CT,
        S_MODE,
        S_MASK,
        S_NAME,
        S_NCHK,
        S_PEN,
        S_ENT,
        S_TRG,
        S_TRB,
        S_GMB,
        S_GMD,
        S_DONE
    } state_t;

endpackage

### rtl/core/tilemap_pixel_renderer_top.sv
// Tilemap pixel renderer: command decode, store memories and the query sequencer.
//
// Usage: one input channel (in_valid/in_ready) carries write and query
// transactions; one output channel (out_valid/out_ready) returns one
// result (drawn, color) per pixel query. Writes give no result.
// A write is taken in the idle state. A pixel query walks the
// single tile RAM port for scroll, control, mask and name words, then
// the char, palette, colour-translate and gamma RAMs one read at a time.
// A query drawn through a window mask passes a mask check state that a
// split mode skips; a query rejected early goes straight to the done
// state. Every memory read is registered. A transaction is accepted only
// in the idle state, so one query is finished before the next is taken.
// After reset the whole tile RAM is cleared to zero, one word a cycle,
// with in_ready low. A finished result sits in an output register; the
// next transaction is accepted while it waits. If the receiver stalls
// and a second result completes, the sequencer holds it until the
// output register frees.
`timescale 1ns / 1ps
module tilemap_pixel_renderer_top
    import tpr_pkg::*;
#(
    parameter int CHAR_WORDS_P    = CHAR_WORDS,
    parameter int SCREEN_WIDTH_P  = SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT_P = SCREEN_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [17:0] addr,
    input  logic [15:0] wdata,
    input  logic [1:0]  layer,
    input  logic        pass,
    input  logic        opaque,
    input  logic [8:0]  pixel_x,
    input  logic [8:0]  pixel_y,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        drawn,
    output logic [23:0] color
);

    localparam int CAW = $clog2(CHAR_WORDS_P);
    localparam logic [19:0] CW1 = 20'(CHAR_WORDS_P);
    localparam logic [19:0] CW2 = 20'(2 * CHAR_WORDS_P);

    logic [15:0] tile_mem [TILE_WORDS];
    logic [15:0] char_mem [CHAR_WORDS_P];
    logic [15:0] pal_mem  [PALETTE_WORDS];
    logic [15:0] xl_mem   [TRANSLATE_WORDS];
    logic [7:0]  gm_mem   [GAMMA_WORDS];

    state_t state_reg, state_next;
    logic [TILE_AW-1:0] clr_reg;

    logic [1:0]  layer_reg;
    logic        pass_reg, opaque_reg;
    logic [8:0]  x_reg, y_reg;
    logic [15:0] hscr_reg, vscr_reg, name_reg, ent_reg;
    logic [1:0]  eff_reg;
    logic [7:0]  r_reg, g_reg;
    logic        res_drawn_reg;
    logic [23:0] res_color_reg;
    logic        out_valid_reg;
    logic        out_drawn_reg;
    logic [23:0] out_color_reg;

    logic [15:0] tile_q, char_q, pal_q, xl_q;
    logic [7:0]  gm_q;

    logic               tile_we;
    logic [TILE_AW-1:0] tile_waddr, tile_raddr;
    logic [15:0]        tile_wdata;
    logic [CAW-1:0]     char_raddr;
    logic [PAL_AW-1:0]  pal_raddr;
    logic [XL_AW-1:0]   xl_raddr;
    logic [GAMMA_AW-1:0] gm_raddr;

    logic        accept, is_query;
    logic        off_screen, split, vdiv, in_first, mask_bit;
    logic [1:0]  first_l, second_l, split_eff;
    logic [15:0] nv, nh;
    logic [8:0]  sx, sy;
    logic [19:0] cw_raw, cw_a, cw_b;
    logic [3:0]  pen;
    logic        res_free;

    assign accept   = in_valid && in_ready;
    assign is_query = (cmd == CMD_QUERY);
    assign res_free = !out_valid_reg || out_ready;

    // query datapath terms
    assign off_screen = ({1'b0, x_reg} >= 10'(SCREEN_WIDTH_P))
                     || ({1'b0, y_reg} >= 10'(SCREEN_HEIGHT_P));
    assign split    = (tile_q[14:13] != 2'd0);
    assign vdiv     = (tile_q[14:13] == MODE_VDIV);
    assign nv       = 16'd0 - vscr_reg;
    assign nh       = 16'd0 - hscr_reg;
    always_comb
    begin
        if (vdiv)
        begin
            in_first = (y_reg < nv[8:0]);
            first_l  = nv[9] ? layer_reg : (layer_reg ^ 2'd1);
        end
        else
        begin
            in_first = (x_reg < hscr_reg[8:0]);
            first_l  = hscr_reg[9] ? layer_reg : (layer_reg ^ 2'd1);
        end
        second_l  = first_l ^ 2'd1;
        split_eff = in_first ? first_l : second_l;
    end
    assign mask_bit = tile_q[4'd15 - x_reg[6:3]];
    assign sx       = x_reg + nh[8:0];
    assign sy       = y_reg + vscr_reg[8:0];
    assign cw_raw   = {2'b00, tile_q[13:0], sy[2:0], sx[2]};
    assign cw_a     = (cw_raw >= CW2) ? (cw_raw - CW2) : cw_raw;
    assign cw_b     = (cw_a >= CW1) ? (cw_a - CW1) : cw_a;
    assign pen      = 4'(char_q >> (5'd12 - {1'b0, sx[1:0], 2'b00}));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_reg == {TILE_AW{1'b1}}) state_next = S_IDLE;
            S_IDLE:  if (accept && is_query) state_next = S_HS;
            S_HS:    state_next = S_VS;
            S_VS:    state_next = S_CT;
            S_CT:    state_next = S_MODE;
            S_MODE:
            begin
                if (off_screen || vscr_reg[15])
                    state_next = S_DONE;
                else if (split)
                    state_next = layer_reg[0] ? S_DONE : S_NAME;
                else
                    state_next = S_MASK;
            end
            S_MASK:  state_next = (mask_bit != layer_reg[0]) ? S_DONE : S_NAME;
            S_NAME:  state_next = S_NCHK;
            S_NCHK:  state_next = (tile_q[15] != pass_reg) ? S_DONE : S_PEN;
            S_PEN:   state_next = (pen == 4'd0 && !opaque_reg) ? S_DONE : S_ENT;
            S_ENT:   state_next = S_TRG;
            S_TRG:   state_next = S_TRB;
            S_TRB:   state_next = S_GMB;
            S_GMB:   state_next = S_GMD;
            S_GMD:   state_next = S_DONE;
            S_DONE:  if (res_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // memory addressing and strobes
    always_comb
    begin
        in_ready   = (state_reg == S_IDLE);
        tile_we    = 1'b0;
        tile_waddr = addr[TILE_AW-1:0];
        tile_wdata = wdata;
        tile_raddr = HSCROLL_BASE + TILE_AW'(layer_reg);
        char_raddr = cw_b[CAW-1:0];
        pal_raddr  = {1'b0, name_reg[14:7], pen};
        xl_raddr   = XL_R + {ent_reg[4:0], 8'h00};
        gm_raddr   = xl_q[7:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                tile_we    = 1'b1;
                tile_waddr = clr_reg;
                tile_wdata = 16'h0000;
            end
            S_IDLE:  tile_we = accept && (cmd == CMD_TILE) && (addr < 18'(TILE_WORDS));
            S_HS:    tile_raddr = HSCROLL_BASE + TILE_AW'(layer_reg);
            S_VS:    tile_raddr = VSCROLL_BASE + TILE_AW'(layer_reg);
            S_CT:    tile_raddr = VSCROLL_BASE + TILE_AW'({layer_reg[1], 1'b0});
            S_MODE:  tile_raddr = (layer_reg[1] ? MASK_HI : MASK_LO)
                                + TILE_AW'({y_reg, 2'b00}) + TILE_AW'(x_reg[8:7]);
            S_NAME:  tile_raddr = {1'b0, eff_reg, sy[8:3], sx[8:3]};
            S_ENT:   xl_raddr = XL_R + {pal_q[4:0], 8'h00};
            S_TRG:   xl_raddr = XL_G + {ent_reg[9:5], 8'h00};
            S_TRB:   xl_raddr = XL_B + {ent_reg[14:10], 8'h00};
            default: ;
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (tile_we)
            tile_mem[tile_waddr] <= tile_wdata;
        tile_q <= tile_mem[tile_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_CHAR && {1'b0, addr} < 19'(CHAR_WORDS_P))
            char_mem[addr[CAW-1:0]] <= wdata;
        char_q <= char_mem[char_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_PAL && addr < 18'(PALETTE_WORDS))
            pal_mem[addr[PAL_AW-1:0]] <= wdata;
        pal_q <= pal_mem[pal_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_XL && addr < 18'(TRANSLATE_WORDS))
            xl_mem[addr[XL_AW-1:0]] <= wdata;
        xl_q <= xl_mem[xl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_GAMMA && addr < 18'(GAMMA_WORDS))
            gm_mem[addr[GAMMA_AW-1:0]] <= wdata[7:0];
        gm_q <= gm_mem[gm_raddr];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == S_DONE && res_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // query payload
    always_ff @(posedge clk)
    begin
        if (accept && is_query)
        begin
            layer_reg  <= layer;
            pass_reg   <= pass;
            opaque_reg <= opaque;
            x_reg      <= pixel_x;
            y_reg      <= pixel_y;
        end
        unique case (state_reg)
            S_HS:
            begin
                res_drawn_reg <= 1'b0;
                res_color_reg <= 24'h000000;
            end
            S_VS:    hscr_reg <= tile_q;
            S_CT:    vscr_reg <= tile_q;
            S_MODE:  eff_reg  <= split ? split_eff : layer_reg;
            S_NCHK:  name_reg <= tile_q;
            S_ENT:   ent_reg  <= {1'b0, pal_q[14:0]};
            S_TRB:   r_reg    <= gm_q;
            S_GMB:   g_reg    <= gm_q;
            S_GMD:
            begin
                res_drawn_reg <= 1'b1;
                res_color_reg <= {gm_q, g_reg, r_reg};
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    out_drawn_reg <= res_drawn_reg;
                    out_color_reg <= res_color_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign drawn     = out_drawn_reg;
    assign color     = out_color_reg;

endmodule
